FILE: design/lsp_pkg.sv
package lsp_pkg;

	localparam int RAND_W    = 32;
	localparam int PIDX_W    = 5;
	localparam int TVAL_W    = 16;
	localparam int DIV_CNT_W = 5;

	typedef enum logic {
		CMD_SET  = 1'b0,
		CMD_DRAW = 1'b1
	} lsp_cmd_t;

	typedef struct packed {
		lsp_cmd_t            cmd;
		logic [PIDX_W-1:0]   proc_index;
		logic [TVAL_W-1:0]   ticket_value;
		logic                is_eligible;
		logic [RAND_W-1:0]   random_word;
	} lsp_req_t;

	typedef struct packed {
		logic [PIDX_W-1:0]   winner_index;
		logic                no_winner;
	} lsp_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_CHECK,
		S_DIV,
		S_WALK,
		S_OUT
	} lsp_state_t;

	typedef struct packed {
		logic wr_en;
		logic start;
		logic issue;
		logic sum_en;
		logic div_init;
		logic div_step;
		logic walk_en;
		logic set_none;
		logic load_out;
	} lsp_ctl_t;

	typedef struct packed {
		logic all_issued;
		logic total_zero;
		logic div_last;
		logic walk_end;
	} lsp_sts_t;

endpackage

FILE: design/lsp_ram.sv
module lsp_ram
	#(
		parameter int WIDTH = 16,
		parameter int DEPTH = 32
	)
	(
		input  logic                     clk,
		input  logic                     we,
		input  logic [$clog2(DEPTH)-1:0] waddr,
		input  logic [WIDTH-1:0]         wdata,
		input  logic [$clog2(DEPTH)-1:0] raddr,
		output logic [WIDTH-1:0]         rdata
	);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/lsp_ctrl.sv
module lsp_ctrl
	import lsp_pkg::*;
	(
		input  logic     clk,
		input  logic     arst_n,
		input  logic     req_valid,
		input  lsp_cmd_t req_cmd,
		output logic     req_stall,
		output logic     rsp_valid,
		input  logic     rsp_stall,
		output lsp_ctl_t ctl,
		input  lsp_sts_t sts
	);

	lsp_state_t state_q, state_d;
	logic       rsp_valid_q;
	logic       out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid && req_cmd == CMD_DRAW) begin
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				if (sts.all_issued) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = sts.total_zero ? S_OUT : S_DIV;
			end
			S_DIV: begin
				if (sts.div_last) begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (sts.walk_end) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.wr_en = (req_cmd == CMD_SET);
					ctl.start = (req_cmd == CMD_DRAW);
				end
			end
			S_SUM: begin
				ctl.issue  = 1'b1;
				ctl.sum_en = 1'b1;
			end
			S_CHECK: begin
				ctl.set_none = sts.total_zero;
				ctl.div_init = !sts.total_zero;
			end
			S_DIV: begin
				ctl.div_step = 1'b1;
			end
			S_WALK: begin
				ctl.issue   = 1'b1;
				ctl.walk_en = 1'b1;
			end
			S_OUT: begin
				ctl.load_out = out_free;
			end
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_rsp_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output state");

	a_div_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && $past(state_q == S_DIV)) |-> $past(sts.div_last))
		else $error("walk started before the reduction finished");

	a_out_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !out_free) |=> (state_q == S_OUT))
		else $error("result dropped while the output register was full");

endmodule

FILE: design/lsp_dpath.sv
module lsp_dpath
	import lsp_pkg::*;
	#(
		parameter int NUM_PROCS   = 32,
		parameter int TICKET_BITS = 16
	)
	(
		input  logic     clk,
		input  logic     arst_n,
		input  lsp_req_t req,
		input  lsp_ctl_t ctl,
		output lsp_sts_t sts,
		output lsp_rsp_t rsp
	);

	localparam int IDX_W = $clog2(NUM_PROCS);
	localparam int SUM_W = TICKET_BITS + IDX_W;
	localparam int CW    = (SUM_W > RAND_W + 1) ? SUM_W : RAND_W + 1;
	localparam int KW    = (SUM_W > RAND_W) ? SUM_W : RAND_W;

	logic [IDX_W+PIDX_W-1:0]      idx_wide;
	logic [TICKET_BITS+TVAL_W-1:0] tv_wide;
	logic                         we;
	logic [IDX_W-1:0]             waddr;
	logic [TICKET_BITS-1:0]       wdata;
	logic [IDX_W-1:0]             raddr;
	logic [TICKET_BITS-1:0]       rdata;
	logic [NUM_PROCS-1:0]         vld_q;

	logic [IDX_W:0]               cnt_q;
	logic                         issue_eff;
	logic                         rd_act_s1;
	logic [IDX_W-1:0]             rd_idx_s1;
	logic                         vld_s1;
	logic [SUM_W-1:0]             eff;

	logic [SUM_W-1:0]             sum_q;
	logic [RAND_W-1:0]            quo_q;
	logic [RAND_W-1:0]            rem_q;
	logic [DIV_CNT_W-1:0]         divcnt_q;
	logic [CW-1:0]                shifted;
	logic [CW-1:0]                sum_ext;
	logic [CW-1:0]                diff;

	logic [SUM_W-1:0]             run_q;
	logic [SUM_W-1:0]             run_next;
	logic                         hit;
	logic                         found_q;
	logic [IDX_W-1:0]             pick_q;
	logic                         none_q;
	logic [IDX_W+PIDX_W-1:0]      pick_wide;

	assign idx_wide = {{IDX_W{1'b0}}, req.proc_index};
	assign tv_wide  = {{TICKET_BITS{1'b0}}, req.ticket_value};
	assign we       = ctl.wr_en && (idx_wide < (IDX_W+PIDX_W)'(NUM_PROCS));
	assign waddr    = idx_wide[IDX_W-1:0];
	assign wdata    = req.is_eligible ? tv_wide[TICKET_BITS-1:0] : '0;
	assign raddr    = cnt_q[IDX_W-1:0];

	lsp_ram #(
		.WIDTH (TICKET_BITS),
		.DEPTH (NUM_PROCS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign issue_eff = ctl.issue && !sts.all_issued && !found_q;
	assign eff       = vld_s1 ? {{IDX_W{1'b0}}, rdata} : '0;

	assign shifted = CW'({rem_q, quo_q[RAND_W-1]});
	assign sum_ext = CW'(sum_q);
	assign diff    = shifted - sum_ext;

	assign run_next = run_q + eff;
	assign hit      = KW'(run_next) > KW'(rem_q);

	assign sts.all_issued = (cnt_q == (IDX_W+1)'(NUM_PROCS));
	assign sts.total_zero = (sum_q == '0);
	assign sts.div_last   = (divcnt_q == DIV_CNT_W'(RAND_W - 1));
	assign sts.walk_end   = found_q || (sts.all_issued && !rd_act_s1);

	assign pick_wide = {{PIDX_W{1'b0}}, pick_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			cnt_q     <= '0;
			rd_act_s1 <= 1'b0;
			found_q   <= 1'b0;
			divcnt_q  <= '0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rd_act_s1 <= issue_eff;
			if (ctl.start || ctl.div_init) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (issue_eff) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (ctl.walk_en && rd_act_s1 && !found_q && hit) begin
					found_q <= 1'b1;
				end
			end
			if (ctl.div_init) begin
				divcnt_q <= '0;
			end else if (ctl.div_step) begin
				divcnt_q <= divcnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue_eff) begin
			rd_idx_s1 <= raddr;
			vld_s1    <= vld_q[raddr];
		end
		if (ctl.start) begin
			quo_q  <= req.random_word;
			sum_q  <= '0;
			run_q  <= '0;
			pick_q <= '0;
			none_q <= 1'b0;
		end else begin
			if (ctl.sum_en && rd_act_s1) begin
				sum_q <= sum_q + eff;
			end
			if (ctl.set_none) begin
				none_q <= 1'b1;
			end
			if (ctl.div_init) begin
				rem_q <= '0;
			end else if (ctl.div_step) begin
				rem_q <= (shifted >= sum_ext) ? diff[RAND_W-1:0] : shifted[RAND_W-1:0];
				quo_q <= {quo_q[RAND_W-2:0], 1'b0};
			end
			if (ctl.walk_en && rd_act_s1 && !found_q) begin
				run_q <= run_next;
				if (hit) begin
					pick_q <= rd_idx_s1;
				end
			end
		end
		if (ctl.load_out) begin
			rsp.no_winner    <= none_q;
			rsp.winner_index <= none_q ? '0 : pick_wide[PIDX_W-1:0];
		end
	end

	a_found_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && ctl.walk_en) |-> (KW'(run_q) > KW'(rem_q)))
		else $error("winner recorded below the winning ticket");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (IDX_W+1)'(NUM_PROCS))
		else $error("table address counter ran past the table");

	a_rem_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.walk_en |-> (CW'(rem_q) < sum_ext))
		else $error("reduced ticket not below the eligible total");

endmodule

FILE: design/lottery_scheduler_pick.sv
// Lottery pick over a table of NUM_PROCS process entries.
// The req channel carries one transaction per command. A set transaction writes
// the ticket count of one entry (zero when it is not eligible) in the cycle it is accepted and
// gives no result; an index beyond the table is ignored. A draw transaction
// gives exactly one rsp transaction: the winning entry, or no_winner with a zero
// index when the eligible tickets sum to zero.
// A draw makes one table pass to total the tickets, 32 steps of the bit-serial
// remainder unit, and a second table pass that stops at the winner; a zero
// total goes straight to the result. Both passes read the single ticket RAM
// port one entry per cycle. A set leaves the controller idle, so sets may
// follow one another back to back.
// req_stall is high while a draw is in progress. A finished result sits in an
// output register; the next transaction is accepted while it waits, and a
// further draw holds its result until rsp_stall releases the register.
// Reset clears every entry to ineligible with no tickets and empties the
// output register; no clearing pass is needed.
module lottery_scheduler_pick
	import lsp_pkg::*;
	#(
		parameter int NUM_PROCS   = 32,
		parameter int TICKET_BITS = 16
	)
	(
		input  logic     clk,
		input  logic     arst_n,
		input  logic     req_valid,
		output logic     req_stall,
		input  lsp_req_t req,
		output logic     rsp_valid,
		input  logic     rsp_stall,
		output lsp_rsp_t rsp
	);

	lsp_ctl_t ctl;
	lsp_sts_t sts;

	lsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req.cmd),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ctl       (ctl),
		.sts       (sts)
	);

	lsp_dpath #(
		.NUM_PROCS   (NUM_PROCS),
		.TICKET_BITS (TICKET_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import lsp_pkg::*;

	localparam int TABLE_SIZE = 32;
	localparam int LONG_HOLD  = 600;
	localparam int SETTLE     = 150;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	lsp_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	lsp_rsp_t rsp;

	lsp_req_t pending_cmds [$];
	lsp_rsp_t expected_picks [$];

	logic              proc_eligible [TABLE_SIZE] = '{default: 1'b0};
	logic [TVAL_W-1:0] proc_tickets [TABLE_SIZE]  = '{default: '0};

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_req       = 0;
	int hold_ack       = 0;
	int hold_left      = 0;
	int error_count    = 0;

	lottery_scheduler_pick dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_error(string msg);
		error_count++;
		if (error_count <= 10) begin
			$display("%0t: %s", $realtime, msg);
		end
	endtask

	// A set updates the table; a draw predicts the winner from the current table.
	task automatic apply_command(lsp_req_t item);
		int unsigned total;
		int unsigned run;
		int unsigned win;
		lsp_rsp_t    pick;
		bit          found;
		if (item.cmd == CMD_SET) begin
			proc_eligible[item.proc_index] = item.is_eligible;
			proc_tickets[item.proc_index]  = item.ticket_value;
		end else begin
			total = 0;
			for (int k = 0; k < TABLE_SIZE; k++) begin
				if (proc_eligible[k]) begin
					total += proc_tickets[k];
				end
			end
			pick = '0;
			if (total == 0) begin
				pick.no_winner = 1'b1;
			end else begin
				win   = item.random_word % total;
				run   = 0;
				found = 1'b0;
				for (int k = 0; k < TABLE_SIZE; k++) begin
					if (!found && proc_eligible[k]) begin
						run += proc_tickets[k];
						if (run > win) begin
							pick.winner_index = PIDX_W'(k);
							found = 1'b1;
						end
					end
				end
			end
			expected_picks.push_back(pick);
		end
	endtask

	function automatic lsp_req_t make_cmd(lsp_cmd_t c, int idx, int tickets, bit elig,
			logic [RAND_W-1:0] word);
		lsp_req_t item;
		item.cmd          = c;
		item.proc_index   = PIDX_W'(idx);
		item.ticket_value = TVAL_W'(tickets);
		item.is_eligible  = elig;
		item.random_word  = word;
		return item;
	endfunction

	function automatic lsp_req_t random_cmd(int draw_pct, int elig_pct);
		lsp_req_t item;
		int       sel;
		item.cmd         = ($urandom_range(99) < draw_pct) ? CMD_DRAW : CMD_SET;
		item.proc_index  = PIDX_W'($urandom_range(TABLE_SIZE - 1));
		item.is_eligible = ($urandom_range(99) < elig_pct);
		sel = $urandom_range(9);
		if (sel == 0) begin
			item.ticket_value = '0;
		end else if (sel == 1) begin
			item.ticket_value = '1;
		end else if (sel <= 5) begin
			item.ticket_value = TVAL_W'($urandom_range(1, 15));
		end else begin
			item.ticket_value = TVAL_W'($urandom);
		end
		sel = $urandom_range(9);
		if (sel == 0) begin
			item.random_word = '0;
		end else if (sel == 1) begin
			item.random_word = '1;
		end else if (sel <= 4) begin
			item.random_word = RAND_W'($urandom_range(255));
		end else begin
			item.random_word = $urandom;
		end
		return item;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				apply_command(req);
			end
			if (!req_valid || !req_stall) begin
				if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req       <= pending_cmds.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
			hold_ack  <= 0;
		end else if (hold_ack != hold_req) begin
			hold_ack  <= hold_req;
			hold_left <= LONG_HOLD;
			rsp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		lsp_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_picks.size() == 0) begin
				flag_error($sformatf("unexpected transaction: winner_index %0d no_winner %0b",
					rsp.winner_index, rsp.no_winner));
			end else begin
				want = expected_picks.pop_front();
				if (rsp.winner_index != want.winner_index || rsp.no_winner != want.no_winner) begin
					flag_error($sformatf(
						"mismatch: expected winner_index %0d no_winner %0b, got %0d %0b",
						want.winner_index, want.no_winner, rsp.winner_index, rsp.no_winner));
				end
			end
		end
	end

	task automatic wait_drain();
		while (pending_cmds.size() != 0 || req_valid || expected_picks.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic run_phase(int count, int send_pct, int recv_pct, int draw_pct, int elig_pct);
		@(negedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		for (int n = 0; n < count; n++) begin
			pending_cmds.push_back(random_cmd(draw_pct, elig_pct));
		end
		wait_drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty table, extreme fields, ineligible and zero-ticket entries.
		pending_cmds.push_back(make_cmd(CMD_DRAW, 0, 0, 1'b0, 32'h0000_0000));
		pending_cmds.push_back(make_cmd(CMD_SET, 31, 16'hFFFF, 1'b1, 32'hFFFF_FFFF));
		pending_cmds.push_back(make_cmd(CMD_SET, 0, 16'hFFFF, 1'b1, 32'h0000_0000));
		pending_cmds.push_back(make_cmd(CMD_DRAW, 31, 16'hFFFF, 1'b1, 32'h0000_0000));
		pending_cmds.push_back(make_cmd(CMD_DRAW, 0, 0, 1'b0, 32'h0000_FFFF));
		pending_cmds.push_back(make_cmd(CMD_DRAW, 0, 0, 1'b0, 32'hFFFF_FFFF));
		pending_cmds.push_back(make_cmd(CMD_SET, 5, 100, 1'b0, 32'h0000_0000));
		pending_cmds.push_back(make_cmd(CMD_DRAW, 0, 0, 1'b0, 32'h0000_FFFF));
		pending_cmds.push_back(make_cmd(CMD_SET, 0, 0, 1'b1, 32'h0000_0000));
		pending_cmds.push_back(make_cmd(CMD_DRAW, 0, 0, 1'b0, 32'h0000_0000));
		pending_cmds.push_back(make_cmd(CMD_SET, 31, 0, 1'b0, 32'h0000_0000));
		pending_cmds.push_back(make_cmd(CMD_DRAW, 0, 0, 1'b0, 32'h0000_007B));
		pending_cmds.push_back(make_cmd(CMD_SET, 16, 1, 1'b1, 32'h0000_0000));
		pending_cmds.push_back(make_cmd(CMD_SET, 17, 1, 1'b1, 32'h0000_0000));
		pending_cmds.push_back(make_cmd(CMD_DRAW, 0, 0, 1'b0, 32'h0000_0000));
		pending_cmds.push_back(make_cmd(CMD_DRAW, 0, 0, 1'b0, 32'h0000_0001));
		pending_cmds.push_back(make_cmd(CMD_DRAW, 0, 0, 1'b0, 32'hFFFF_FFFF));
		pending_cmds.push_back(make_cmd(CMD_SET, 16, 0, 1'b0, 32'h0000_0000));
		pending_cmds.push_back(make_cmd(CMD_SET, 17, 0, 1'b0, 32'h0000_0000));
		pending_cmds.push_back(make_cmd(CMD_SET, 0, 0, 1'b0, 32'h0000_0000));
		wait_drain();

		run_phase(90, 0, 0, 35, 50);
		run_phase(90, 56, 0, 35, 85);
		run_phase(90, 0, 56, 35, 15);
		run_phase(90, 29, 29, 35, 40);

		// The receiver holds off while draws keep coming, so the block fills and stalls.
		@(negedge clk);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = hold_req + 1;
		for (int n = 0; n < 24; n++) begin
			pending_cmds.push_back(random_cmd(70, 60));
		end
		while (hold_ack != hold_req || hold_left != 0) begin
			@(negedge clk);
		end
		wait_drain();

		repeat (SETTLE) @(negedge clk);
		if (expected_picks.size() != 0) begin
			flag_error($sformatf("%0d expected transactions never arrived",
				expected_picks.size()));
		end
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
